[hw/rtl/motor_power_ramp_macros.svh]
// assertion helpers used by the motor power ramp rtl
// each macro expects clk and rst in scope
`ifndef MOTOR_POWER_RAMP_MACROS_SVH
`define MOTOR_POWER_RAMP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define MPR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define MPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/mpr_pkg.sv]
// ----------------------------------------------------------------------------
// mpr_pkg
// shared widths, register codes, config struct and small helper functions
// ----------------------------------------------------------------------------
package mpr_pkg;

  localparam int FIELD_W   = 8;
  localparam int CFG_W     = 7;
  localparam int NUM_CFG   = 3;
  localparam int CFG_IDX_W = $clog2(NUM_CFG);
  localparam int WIDE_W    = 10;
  localparam int PROD_W    = 14;
  localparam int STEP_W    = 4;
  localparam int MUL_CNT_W = $clog2(FIELD_W);
  localparam int DIV_CNT_W = $clog2(PROD_W);

  localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DECEL    = CFG_IDX_W'(2);

  localparam logic [CFG_W-1:0] MIN_STEP_RESET = CFG_W'(32);
  localparam logic [CFG_W-1:0] ACCEL_RESET    = CFG_W'(30);
  localparam logic [CFG_W-1:0] DECEL_RESET    = CFG_W'(100);

  localparam logic signed [FIELD_W-1:0] LEVEL_RESET = FIELD_W'(16);
  localparam int SAT_MAX = 127;
  localparam logic signed [FIELD_W-1:0] SAT_POS = FIELD_W'(SAT_MAX);
  localparam logic signed [FIELD_W-1:0] SAT_NEG = FIELD_W'(-SAT_MAX);

  // x / 10 as (x * 205) >> 11, exact for all 7-bit x
  localparam int STEP_DIV     = 10;
  localparam int DIV10_SHIFT  = 11;
  localparam int DIV10_MUL    = ((1 << DIV10_SHIFT) + STEP_DIV - 1) / STEP_DIV;
  localparam int DIV10_PROD_W = CFG_W + 8;

  typedef struct packed {
    logic [CFG_W-1:0] min_step;
    logic [CFG_W-1:0] accel;
    logic [CFG_W-1:0] decel;
  } cfg_t;

  function automatic logic [STEP_W-1:0] div10(input logic [CFG_W-1:0] x);
    logic [DIV10_PROD_W-1:0] prod;
    prod = DIV10_PROD_W'(x) * DIV10_PROD_W'(DIV10_MUL);
    return prod[DIV10_SHIFT +: STEP_W];
  endfunction

  function automatic logic [FIELD_W-1:0] mag8(input logic signed [FIELD_W-1:0] v);
    return v[FIELD_W-1] ? FIELD_W'(-v) : FIELD_W'(v);
  endfunction

  function automatic logic signed [FIELD_W-1:0] sat_wide(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(SAT_MAX);
    lo = WIDE_W'(-SAT_MAX);
    if (v > hi) return SAT_POS;
    if (v < lo) return SAT_NEG;
    return FIELD_W'(v);
  endfunction

endpackage

[hw/rtl/mpr_in_if.sv]
// ----------------------------------------------------------------------------
// mpr_in_if
// command tick channel: valid/ready plus one tick of payload
// ----------------------------------------------------------------------------
interface mpr_in_if;
  import mpr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic signed [FIELD_W-1:0] target_left;
  logic signed [FIELD_W-1:0] target_right;
  logic                      cmd_accepted;

  modport source (output valid, mode, target_left, target_right, cmd_accepted,
                  input ready);
  modport sink   (input valid, mode, target_left, target_right, cmd_accepted,
                  output ready);
endinterface

[hw/rtl/mpr_out_if.sv]
// ----------------------------------------------------------------------------
// mpr_out_if
// result channel: valid/ready plus drive values, level and done flag
// ----------------------------------------------------------------------------
interface mpr_out_if;
  import mpr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] drive_left;
  logic signed [FIELD_W-1:0] drive_right;
  logic signed [FIELD_W-1:0] power_level;
  logic                      ramp_done;

  modport source (output valid, drive_left, drive_right, power_level, ramp_done,
                  input ready);
  modport sink   (input valid, drive_left, drive_right, power_level, ramp_done,
                  output ready);
endinterface

[hw/rtl/mpr_ramp.sv]
// ----------------------------------------------------------------------------
// mpr_ramp
// one ramp step of the power level toward the two wheel targets
// ----------------------------------------------------------------------------
module mpr_ramp (
  input  mpr_pkg::cfg_t                      cfg,
  input  logic signed [mpr_pkg::FIELD_W-1:0] level,
  input  logic signed [mpr_pkg::FIELD_W-1:0] target_left,
  input  logic signed [mpr_pkg::FIELD_W-1:0] target_right,
  output logic signed [mpr_pkg::FIELD_W-1:0] level_next
);
  import mpr_pkg::*;

  logic signed [WIDE_W-1:0] p, tl, tr, m, neg_m, a, a_step, d_step;
  logic signed [WIDE_W-1:0] hi, lo, q;

  always_comb begin
    p      = WIDE_W'(level);
    tl     = WIDE_W'(target_left);
    tr     = WIDE_W'(target_right);
    m      = $signed({{(WIDE_W-CFG_W){1'b0}}, cfg.min_step});
    a      = $signed({{(WIDE_W-CFG_W){1'b0}}, cfg.accel});
    neg_m  = -m;
    a_step = $signed({{(WIDE_W-STEP_W){1'b0}}, div10(cfg.accel)});
    d_step = $signed({{(WIDE_W-STEP_W){1'b0}}, div10(cfg.decel)});
    hi     = (tl > tr) ? tl : tr;
    lo     = (tl < tr) ? tl : tr;
    q      = p;

    if (tl > 0 && tr > 0) begin
      // forward
      if (p > neg_m && p < m) q = m;
      else if (p > a + tl && p > a + tr) q = hi - a;
      else if (p < neg_m) q = p + d_step;
      else q = p + a_step;
      if (q > tl || q > tr) q = hi;
    end else if (tl < 0 && tr < 0) begin
      // reverse
      if (p > neg_m && p < m) q = neg_m;
      else if (p < tl - a && p < tr - a) q = hi - a;
      else if (p > m) q = p - d_step;
      else q = p - a_step;
      if (q < tl || q < tr) q = lo;
    end else begin
      // mixed signs or a zero target
      if (p < m) q = m;
      else if (p < tl || p < tr) q = p + a_step;
      if (q > tl && q > tr) q = hi;
    end

    level_next = sat_wide(q);
  end

endmodule

[hw/rtl/mpr_mul.sv]
// ----------------------------------------------------------------------------
// mpr_mul
// bit-serial shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module mpr_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [mpr_pkg::CFG_W-1:0]    mcand,
  input  logic [mpr_pkg::FIELD_W-1:0]  mplier,
  output logic                         done,
  output logic [mpr_pkg::PROD_W-1:0]   product
);
  import mpr_pkg::*;

  localparam logic [MUL_CNT_W-1:0] LAST = MUL_CNT_W'(FIELD_W - 1);

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [PROD_W-1:0]    acc;
  logic [PROD_W-1:0]    mcand_sh;
  logic [FIELD_W-1:0]   mplier_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc       <= '0;
      mcand_sh  <= PROD_W'(mcand);
      mplier_sh <= mplier;
    end else if (busy) begin
      if (mplier_sh[0]) acc <= acc + mcand_sh;
      mcand_sh  <= {mcand_sh[PROD_W-2:0], 1'b0};
      mplier_sh <= {1'b0, mplier_sh[FIELD_W-1:1]};
    end
  end

  assign product = acc;

endmodule

[hw/rtl/mpr_div.sv]
// ----------------------------------------------------------------------------
// mpr_div
// restoring divider, one quotient bit per cycle, msb first
// ----------------------------------------------------------------------------
module mpr_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mpr_pkg::PROD_W-1:0]  dividend,
  input  logic [mpr_pkg::FIELD_W-1:0] divisor,
  output logic                        done,
  output logic [mpr_pkg::PROD_W-1:0]  quotient
);
  import mpr_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(PROD_W - 1);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [PROD_W-1:0]    dvd;
  logic [FIELD_W-1:0]   dvs;
  logic [FIELD_W-1:0]   rem;
  logic [FIELD_W:0]     shifted;
  logic [FIELD_W:0]     diff;
  logic                 ge;

  always_comb begin
    shifted = {rem, dvd[PROD_W-1]};
    diff    = shifted - {1'b0, dvs};
    ge      = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) busy <= 1'b0;
      end
    end
  end

  // quotient bits shift into the low end of the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff[FIELD_W-1:0] : shifted[FIELD_W-1:0];
      dvd <= {dvd[PROD_W-2:0], ge};
    end
  end

  assign quotient = dvd;

endmodule

[hw/rtl/motor_power_ramp.sv]
// ----------------------------------------------------------------------------
// motor_power_ramp
// motor power slew-rate limiter with bit-serial drive ratio
// ----------------------------------------------------------------------------
// One command tick is handled at a time. A ramp tick first steps the power
// level in the ramp state, then runs the bit-serial multiplier (level times
// the stronger-side target, 8 multiplier bits one a cycle) and the restoring
// divider (14 quotient bits one a cycle), then forms the result in the finish
// state, which waits while the output register still holds an untaken beat.
// A stop tick goes from the ramp state straight to the finish state. The next
// tick is accepted the cycle after the result is loaded into the output
// register, even if the result beat is still waiting downstream. Config
// writes (min_step_power, accel_power, decel_power at indexes 0..2) are taken
// any cycle, but belong between ticks.
// ----------------------------------------------------------------------------
module motor_power_ramp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [mpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpr_pkg::CFG_W-1:0]     cfg_wr_data,
  mpr_in_if.sink                        in_ch,
  mpr_out_if.source                     out_ch
);
  import mpr_pkg::*;
  `include "motor_power_ramp_macros.svh"

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RAMP   = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state;
  cfg_t       cfg;

  // level held between ticks
  logic signed [FIELD_W-1:0] level;

  // captured tick
  logic                      stop_q;
  logic                      acc_q;
  logic signed [FIELD_W-1:0] tl_q;
  logic signed [FIELD_W-1:0] tr_q;

  // results of the ramp cycle
  logic signed [FIELD_W-1:0] lvl_new;
  logic                      left_small;
  logic                      ratio_neg;
  logic                      den_zero;
  logic [FIELD_W-1:0]        den_mag;

  // ramp step and operand selection
  logic signed [FIELD_W-1:0] ramp_out;
  logic [FIELD_W-1:0]        mag_l, mag_r, mag_p, num_mag, den_mag_c;
  logic                      small_c;

  // serial units
  logic                mul_start, mul_done;
  logic [PROD_W-1:0]   product;
  logic                div_start, div_done;
  logic [PROD_W-1:0]   quotient;

  // result forming
  logic                      fin_go;
  logic [CFG_W-1:0]          q_sat;
  logic signed [FIELD_W-1:0] ratio_val;
  logic signed [FIELD_W-1:0] lvl_final;

  // output register
  logic                      out_valid;
  logic signed [FIELD_W-1:0] out_dl, out_dr, out_pl;
  logic                      out_done;

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_step <= MIN_STEP_RESET;
      cfg.accel    <= ACCEL_RESET;
      cfg.decel    <= DECEL_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MIN_STEP: cfg.min_step <= cfg_wr_data;
        REG_ACCEL:    cfg.accel    <= cfg_wr_data;
        REG_DECEL:    cfg.decel    <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // ---------------- ramp step ----------------
  mpr_ramp u_ramp (
    .cfg          (cfg),
    .level        (level),
    .target_left  (tl_q),
    .target_right (tr_q),
    .level_next   (ramp_out)
  );

  // weaker side gets the level, the other side level * num / den
  always_comb begin
    mag_l     = mag8(tl_q);
    mag_r     = mag8(tr_q);
    mag_p     = mag8(ramp_out);
    small_c   = mag_l < mag_r;
    num_mag   = small_c ? mag_r : mag_l;
    den_mag_c = small_c ? mag_l : mag_r;
  end

  assign mul_start = (state == ST_RAMP) && !stop_q;
  assign div_start = (state == ST_MUL) && mul_done;

  mpr_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mag_p[CFG_W-1:0]),
    .mplier  (num_mag),
    .done    (mul_done),
    .product (product)
  );

  mpr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (den_mag),
    .done     (div_done),
    .quotient (quotient)
  );

  // ---------------- result forming ----------------
  always_comb begin
    fin_go    = !out_valid || out_ch.ready;
    // quotient magnitude saturates at full scale
    q_sat     = (quotient > PROD_W'(SAT_MAX)) ? CFG_W'(SAT_MAX) : quotient[CFG_W-1:0];
    if (den_zero) ratio_val = '0;
    else if (ratio_neg) ratio_val = -$signed({1'b0, q_sat});
    else ratio_val = $signed({1'b0, q_sat});
    // a rejected command keeps the previous level
    lvl_final = acc_q ? lvl_new : level;
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      level     <= LEVEL_RESET;
      out_valid <= 1'b0;
    end else begin
      // loading a new beat takes priority over retiring the old one
      if (state == ST_FINISH && fin_go) out_valid <= 1'b1;
      else if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_ch.valid) state <= ST_RAMP;
        end
        ST_RAMP: begin
          state <= stop_q ? ST_FINISH : ST_MUL;
        end
        ST_MUL: begin
          if (mul_done) state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (fin_go) begin
            level <= stop_q ? '0 : lvl_final;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_ch.valid) begin
      stop_q <= in_ch.mode;
      acc_q  <= in_ch.cmd_accepted;
      tl_q   <= in_ch.target_left;
      tr_q   <= in_ch.target_right;
    end
    if (state == ST_RAMP) begin
      lvl_new    <= ramp_out;
      left_small <= small_c;
      den_mag    <= den_mag_c;
      den_zero   <= (den_mag_c == '0);
      // sign of level * num / den
      ratio_neg  <= ramp_out[FIELD_W-1] ^ (small_c ? tr_q[FIELD_W-1] : tl_q[FIELD_W-1])
                    ^ (small_c ? tl_q[FIELD_W-1] : tr_q[FIELD_W-1]);
    end
    if (state == ST_FINISH && fin_go) begin
      if (stop_q) begin
        out_dl   <= '0;
        out_dr   <= '0;
        out_pl   <= '0;
        out_done <= 1'b1;
      end else begin
        out_dl   <= left_small ? lvl_new : ratio_val;
        out_dr   <= left_small ? ratio_val : lvl_new;
        out_pl   <= lvl_final;
        out_done <= (tl_q == lvl_final) || (tr_q == lvl_final);
      end
    end
  end

  assign in_ch.ready        = (state == ST_IDLE);
  assign out_ch.valid       = out_valid;
  assign out_ch.drive_left  = out_dl;
  assign out_ch.drive_right = out_dr;
  assign out_ch.power_level = out_pl;
  assign out_ch.ramp_done   = out_done;

  // ---------------- assertions ----------------
  `MPR_ASSERT_SAME(a_level_range, 1'b1, (level >= SAT_NEG) && (level <= SAT_POS), "bad level")
  `MPR_ASSERT_NEXT(a_accept_leaves_idle, in_ch.valid && in_ch.ready, state != ST_IDLE, "no start")
  `MPR_ASSERT_SAME(a_div_done_state, div_done, state == ST_DIV, "divider done out of phase")
  `MPR_ASSERT_NEXT(a_stop_zeroes, (state == ST_FINISH) && fin_go && stop_q, level == '0, "stop")

endmodule
